>>> sv/bfha_pkg.sv
`timescale 1ns / 1ps

package bfha_pkg;

  // Heap geometry.
  localparam int unsigned HeapUnits  = 2048;
  localparam int unsigned UnitW      = $clog2(HeapUnits);
  localparam int unsigned CntW       = UnitW + 1;
  localparam int unsigned UnitShift  = 5;
  localparam logic [CntW-1:0] InitUnits = CntW'(128);
  localparam logic [31:0] HeapBaseReset = 32'hC040_0000;
  localparam logic [31:0] HeadBytes     = 32'd8;

  // Operation codes.
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // Result status codes.
  localparam logic [1:0] StAllocated = 2'd0;
  localparam logic [1:0] StFreed     = 2'd1;
  localparam logic [1:0] StIgnored   = 2'd2;
  localparam logic [1:0] StNoMemory  = 2'd3;

  typedef enum logic [1:0] {
    TAG_NONE = 2'd0,
    TAG_FREE = 2'd1,
    TAG_USED = 2'd2
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [CntW-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic        op;
    logic [15:0] bytes;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic             valid;
    logic [UnitW-1:0] unit;
    logic [1:0]       status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_A_RD, S_A_EV, S_A_DEC, S_A_SP2, S_A_APL, S_A_APH,
    S_F_CHK, S_F_NX, S_F_LK, S_F_LKW, S_F_PH, S_F_CLR, S_RESP
  } state_t;

endpackage

>>> sv/bfha_engine.sv
`timescale 1ns / 1ps

module bfha_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          heap_base,
  input  logic                 req_valid,
  input  bfha_pkg::req_t       req,
  output logic                 req_ready,
  input  logic                 rsp_take,
  output bfha_pkg::rsp_t       rsp
);

  localparam int unsigned UW = bfha_pkg::UnitW;
  localparam int unsigned CW = bfha_pkg::CntW;

  // Header and footer-link memories.
  bfha_pkg::hdr_t hdr_mem [bfha_pkg::HeapUnits];
  logic [UW-1:0]  link_mem [bfha_pkg::HeapUnits];

  bfha_pkg::hdr_t hdr_rd, hdr_wd;
  logic [UW-1:0]  hdr_ra, hdr_wa, link_ra, link_wa, link_wd, link_rd;
  logic           hdr_we, link_we;

  bfha_pkg::state_t state_r, state_nxt;

  logic [CW:0]   u_r;
  logic [CW-1:0] end_r, need_r, best_sz_r, sz_h_r;
  logic [UW-1:0] best_u_r, h_r, p_r, nx_r, clr_r, res_unit_r;
  logic          have_best_r;
  logic [1:0]    res_status_r;

  // Free address decode and size arithmetic.
  logic [31:0]   off;
  logic          free_ok;
  logic [CW:0]   nx_sum;
  logic [CW-1:0] need_calc;
  logic [16:0]   need_sum;
  logic [CW:0]   room;

  assign off       = req.addr - heap_base - bfha_pkg::HeadBytes;
  assign free_ok   = (req.addr != 32'd0) && (off[bfha_pkg::UnitShift-1:0] == '0)
                     && ({5'd0, off[31:bfha_pkg::UnitShift]} < {20'd0, end_r});
  assign need_sum  = {1'b0, req.bytes} + 17'd47;
  assign need_calc = need_sum[16:bfha_pkg::UnitShift];
  assign nx_sum    = {2'b0, h_r} + {1'b0, hdr_rd.size};
  assign room      = CW'(bfha_pkg::HeapUnits) - {1'b0, end_r};

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_wa] <= hdr_wd;
    end
    hdr_rd <= hdr_mem[hdr_ra];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd <= link_mem[link_ra];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bfha_pkg::S_CLR: begin
        if (clr_r == UW'(bfha_pkg::HeapUnits - 1)) state_nxt = bfha_pkg::S_IDLE;
      end
      bfha_pkg::S_IDLE: begin
        if (req_valid) begin
          if (req.op == bfha_pkg::OpAlloc) state_nxt = bfha_pkg::S_A_RD;
          else if (free_ok) state_nxt = bfha_pkg::S_F_CHK;
          else state_nxt = bfha_pkg::S_RESP;
        end
      end
      bfha_pkg::S_A_RD: begin
        state_nxt = (u_r < {1'b0, end_r}) ? bfha_pkg::S_A_EV : bfha_pkg::S_A_DEC;
      end
      bfha_pkg::S_A_EV: begin
        if (hdr_rd.tag == bfha_pkg::TAG_FREE && hdr_rd.size == need_r) begin
          state_nxt = bfha_pkg::S_RESP;
        end else begin
          state_nxt = bfha_pkg::S_A_RD;
        end
      end
      bfha_pkg::S_A_DEC: begin
        if (have_best_r) begin
          state_nxt = (best_sz_r - need_r > CW'(1)) ? bfha_pkg::S_A_SP2 : bfha_pkg::S_RESP;
        end else if ({1'b0, need_r} > room) begin
          state_nxt = bfha_pkg::S_RESP;
        end else begin
          state_nxt = bfha_pkg::S_A_APL;
        end
      end
      bfha_pkg::S_A_SP2: state_nxt = bfha_pkg::S_RESP;
      bfha_pkg::S_A_APL: state_nxt = bfha_pkg::S_A_APH;
      bfha_pkg::S_A_APH: state_nxt = bfha_pkg::S_RESP;
      bfha_pkg::S_F_CHK: begin
        if (hdr_rd.tag != bfha_pkg::TAG_USED) state_nxt = bfha_pkg::S_RESP;
        else if (nx_sum < {1'b0, end_r}) state_nxt = bfha_pkg::S_F_NX;
        else state_nxt = bfha_pkg::S_F_LK;
      end
      bfha_pkg::S_F_NX: state_nxt = bfha_pkg::S_F_LK;
      bfha_pkg::S_F_LK: begin
        state_nxt = (h_r == '0) ? bfha_pkg::S_RESP : bfha_pkg::S_F_LKW;
      end
      bfha_pkg::S_F_LKW: state_nxt = bfha_pkg::S_F_PH;
      bfha_pkg::S_F_PH: begin
        state_nxt = (hdr_rd.tag == bfha_pkg::TAG_FREE) ? bfha_pkg::S_F_CLR : bfha_pkg::S_RESP;
      end
      bfha_pkg::S_F_CLR: state_nxt = bfha_pkg::S_RESP;
      bfha_pkg::S_RESP: begin
        if (rsp_take) state_nxt = bfha_pkg::S_IDLE;
      end
      default: state_nxt = bfha_pkg::S_IDLE;
    endcase
  end

  // Memory addresses and writes.
  always_comb begin
    hdr_ra  = u_r[UW-1:0];
    link_ra = h_r - UW'(1);
    hdr_we  = 1'b0;
    hdr_wa  = h_r;
    hdr_wd  = '0;
    link_we = 1'b0;
    link_wa = h_r;
    link_wd = h_r;
    unique case (state_r)
      bfha_pkg::S_CLR: begin
        hdr_we = 1'b1;
        hdr_wa = clr_r;
        if (clr_r == '0) hdr_wd = '{tag: bfha_pkg::TAG_FREE, size: bfha_pkg::InitUnits};
        link_we = (clr_r == UW'(bfha_pkg::InitUnits - CW'(1)));
        link_wa = clr_r;
        link_wd = '0;
      end
      bfha_pkg::S_IDLE: hdr_ra = off[bfha_pkg::UnitShift +: UW];
      bfha_pkg::S_A_EV: begin
        if (hdr_rd.tag == bfha_pkg::TAG_FREE && hdr_rd.size == need_r) begin
          hdr_we = 1'b1;
          hdr_wa = u_r[UW-1:0];
          hdr_wd = '{tag: bfha_pkg::TAG_USED, size: hdr_rd.size};
        end
      end
      bfha_pkg::S_A_DEC: begin
        link_ra = UW'(end_r - CW'(1));
        if (have_best_r) begin
          hdr_we = 1'b1;
          hdr_wa = best_u_r;
          if (best_sz_r - need_r > CW'(1)) begin
            hdr_wd  = '{tag: bfha_pkg::TAG_USED, size: need_r};
            link_we = 1'b1;
            link_wa = UW'({1'b0, best_u_r} + need_r - CW'(1));
            link_wd = best_u_r;
          end else begin
            hdr_wd = '{tag: bfha_pkg::TAG_USED, size: best_sz_r};
          end
        end
      end
      bfha_pkg::S_A_SP2: begin
        hdr_we  = 1'b1;
        hdr_wa  = UW'({1'b0, best_u_r} + need_r);
        hdr_wd  = '{tag: bfha_pkg::TAG_FREE, size: best_sz_r - need_r};
        link_we = 1'b1;
        link_wa = UW'({1'b0, best_u_r} + best_sz_r - CW'(1));
        link_wd = UW'({1'b0, best_u_r} + need_r);
      end
      bfha_pkg::S_A_APL: hdr_ra = link_rd;
      bfha_pkg::S_A_APH: begin
        hdr_we  = 1'b1;
        link_we = 1'b1;
        link_wa = UW'(end_r + need_r - CW'(1));
        if (hdr_rd.tag == bfha_pkg::TAG_FREE) begin
          hdr_wa  = p_r;
          hdr_wd  = '{tag: bfha_pkg::TAG_USED, size: hdr_rd.size + need_r};
          link_wd = p_r;
        end else begin
          hdr_wa  = UW'(end_r);
          hdr_wd  = '{tag: bfha_pkg::TAG_USED, size: need_r};
          link_wd = UW'(end_r);
        end
      end
      bfha_pkg::S_F_CHK: hdr_ra = UW'(nx_sum);
      bfha_pkg::S_F_NX: begin
        if (hdr_rd.tag == bfha_pkg::TAG_FREE) begin
          hdr_we  = 1'b1;
          hdr_wa  = nx_r;
          link_we = 1'b1;
          link_wa = UW'({1'b0, nx_r} + hdr_rd.size - CW'(1));
          link_wd = h_r;
        end
      end
      bfha_pkg::S_F_LK: begin
        if (h_r == '0) begin
          hdr_we = 1'b1;
          hdr_wd = '{tag: bfha_pkg::TAG_FREE, size: sz_h_r};
        end
      end
      bfha_pkg::S_F_LKW: hdr_ra = link_rd;
      bfha_pkg::S_F_PH: begin
        hdr_we = 1'b1;
        if (hdr_rd.tag == bfha_pkg::TAG_FREE) begin
          hdr_wa  = p_r;
          hdr_wd  = '{tag: bfha_pkg::TAG_FREE, size: hdr_rd.size + sz_h_r};
          link_we = 1'b1;
          link_wa = UW'({1'b0, h_r} + sz_h_r - CW'(1));
          link_wd = p_r;
        end else begin
          hdr_wd = '{tag: bfha_pkg::TAG_FREE, size: sz_h_r};
        end
      end
      bfha_pkg::S_F_CLR: hdr_we = 1'b1;
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfha_pkg::S_CLR;
      clr_r   <= '0;
      end_r   <= bfha_pkg::InitUnits;
    end else begin
      state_r <= state_nxt;
      if (state_r == bfha_pkg::S_CLR) clr_r <= clr_r + UW'(1);
      if (state_r == bfha_pkg::S_A_APH) end_r <= end_r + need_r;
    end
  end

  // Walk and result registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      bfha_pkg::S_IDLE: begin
        u_r          <= '0;
        have_best_r  <= 1'b0;
        best_sz_r    <= '0;
        best_u_r     <= '0;
        need_r       <= need_calc;
        h_r          <= off[bfha_pkg::UnitShift +: UW];
        res_unit_r   <= '0;
        res_status_r <= bfha_pkg::StIgnored;
      end
      bfha_pkg::S_A_EV: begin
        if (hdr_rd.tag == bfha_pkg::TAG_FREE && hdr_rd.size == need_r) begin
          res_unit_r   <= u_r[UW-1:0];
          res_status_r <= bfha_pkg::StAllocated;
        end else begin
          if (hdr_rd.tag == bfha_pkg::TAG_FREE && need_r < hdr_rd.size
              && (!have_best_r || hdr_rd.size < best_sz_r)) begin
            have_best_r <= 1'b1;
            best_sz_r   <= hdr_rd.size;
            best_u_r    <= u_r[UW-1:0];
          end
          u_r <= u_r + ((hdr_rd.size == '0) ? (CW+1)'(1) : {1'b0, hdr_rd.size});
        end
      end
      bfha_pkg::S_A_DEC: begin
        if (have_best_r) begin
          res_unit_r   <= best_u_r;
          res_status_r <= bfha_pkg::StAllocated;
        end else begin
          res_status_r <= bfha_pkg::StNoMemory;
        end
      end
      bfha_pkg::S_A_APL: p_r <= link_rd;
      bfha_pkg::S_A_APH: begin
        res_unit_r   <= (hdr_rd.tag == bfha_pkg::TAG_FREE) ? p_r : UW'(end_r);
        res_status_r <= bfha_pkg::StAllocated;
      end
      bfha_pkg::S_F_CHK: begin
        sz_h_r <= hdr_rd.size;
        nx_r   <= UW'(nx_sum);
        if (hdr_rd.tag == bfha_pkg::TAG_USED) res_status_r <= bfha_pkg::StFreed;
      end
      bfha_pkg::S_F_NX: begin
        if (hdr_rd.tag == bfha_pkg::TAG_FREE) sz_h_r <= sz_h_r + hdr_rd.size;
      end
      bfha_pkg::S_F_LKW: p_r <= link_rd;
      default: begin
      end
    endcase
  end

  assign req_ready = (state_r == bfha_pkg::S_IDLE);
  assign rsp       = '{valid: (state_r == bfha_pkg::S_RESP), unit: res_unit_r,
                       status: res_status_r};

  logic req_fire;
  assign req_fire = req_valid && req_ready;

  // The heap never grows past its capacity.
  a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
    end_r <= CW'(bfha_pkg::HeapUnits))
    else $error("heap end past capacity");

  // No memory write while waiting for a request.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bfha_pkg::S_IDLE |-> !hdr_we && !link_we)
    else $error("memory write while idle");

  // An accepted request always starts work.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    req_fire |=> state_r != bfha_pkg::S_IDLE)
    else $error("request dropped");

  // The heap end only moves on an append.
  a_end_move: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) != bfha_pkg::S_A_APH && $past(rst_n) |-> $stable(end_r))
    else $error("heap end moved outside an append");

endmodule

>>> sv/best_fit_heap_allocator.sv
`timescale 1ns / 1ps
// Best-fit heap allocator in 32-byte units with boundary tags.
// Input channel (in_valid/in_stall): in_operation selects allocate or free;
// in_request_bytes sizes an allocate, in_address names the payload to free.
// Output channel (out_valid/out_stall): one result per request, carrying
// out_address_out (payload address for a successful allocate, else 0) and out_status.
// cfg_we/cfg_wdata write heap_base; write it only while the block is idle.
// An allocate walks the block list, reading and then evaluating each block
// header, then decides, updates the tags and registers the result. A free
// checks the freed block, merges a free right neighbour, then a free left
// neighbour, before the result. The walk is paced by the single read port
// of the header memory, one read per step.
// One request is in work at a time; a finished result sits in the output
// register, so the next request is accepted while it waits.
// Reset: a clearing pass writes every header entry, during which
// in_stall is high. Afterwards unit 0 is one free block of 128 units.
// A stalled result holds steady on the output until taken.

module best_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [15:0] in_request_bytes,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_address_out,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]    heap_base_r;
  logic           out_valid_r;
  logic [31:0]    out_addr_r;
  logic [1:0]     out_status_r;
  logic           eng_ready, rsp_take;
  bfha_pkg::req_t req;
  bfha_pkg::rsp_t rsp;

  assign req = '{op: in_operation, bytes: in_request_bytes, addr: in_address};

  bfha_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .heap_base (heap_base_r),
    .req_valid (in_valid),
    .req       (req),
    .req_ready (eng_ready),
    .rsp_take  (rsp_take),
    .rsp       (rsp)
  );

  assign in_stall = !eng_ready;
  assign rsp_take = rsp.valid && (!out_valid_r || !out_stall);

  // Base address register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= bfha_pkg::HeapBaseReset;
    end else if (cfg_we) begin
      heap_base_r <= cfg_wdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_take) begin
      out_status_r <= rsp.status;
      out_addr_r   <= (rsp.status == bfha_pkg::StAllocated)
                      ? heap_base_r + {16'd0, rsp.unit, 5'd0} + bfha_pkg::HeadBytes
                      : 32'd0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_address_out = out_addr_r;
  assign out_status      = out_status_r;

endmodule

>>> tb/sv/heap_result_checker.sv
`timescale 1ns / 1ps

module heap_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_operation,
  input  logic [15:0] in_request_bytes,
  input  logic [31:0] in_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_address_out,
  input  logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [31:0] addr;
    logic [1:0]  status;
  } reply_t;

  // Shadow copy of the heap bookkeeping.
  bfha_pkg::tag_t             tags  [bfha_pkg::HeapUnits];
  logic [bfha_pkg::CntW-1:0]  sizes [bfha_pkg::HeapUnits];
  logic [bfha_pkg::UnitW-1:0] links [bfha_pkg::HeapUnits];
  logic [bfha_pkg::CntW-1:0]  end_unit;
  logic [31:0]                base;
  reply_t                     awaited_replies[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void clear_heap();
    for (int i = 0; i < bfha_pkg::HeapUnits; i++) begin
      tags[i] = bfha_pkg::TAG_NONE;
      sizes[i] = '0;
      links[i] = '0;
    end
    tags[0] = bfha_pkg::TAG_FREE;
    sizes[0] = bfha_pkg::InitUnits;
    links[bfha_pkg::InitUnits - 1] = '0;
    end_unit = bfha_pkg::InitUnits;
    base = bfha_pkg::HeapBaseReset;
  endfunction

  function automatic logic [31:0] payload_of(int unsigned unit);
    return base + 32'(unit) * 32'd32 + bfha_pkg::HeadBytes;
  endfunction

  // Best-fit allocate: exact match wins, else first smallest larger block,
  // else append at the heap end.
  function automatic reply_t predict_alloc(logic [15:0] bytes);
    int unsigned need, endu, u, sz, best_u, best_sz, nh, last, p, tail;
    bit exact, have_best;
    reply_t r;
    need = (32'(bytes) + 47) / 32;
    endu = end_unit;
    u = 0;
    best_u = 0;
    best_sz = 32'hFFFF_FFFF;
    exact = 0;
    have_best = 0;
    r.addr = '0;
    r.status = bfha_pkg::StAllocated;
    while (u < endu && u < bfha_pkg::HeapUnits) begin
      sz = sizes[u];
      if (tags[u] == bfha_pkg::TAG_FREE) begin
        if (sz == need) begin
          exact = 1;
          break;
        end
        if (need < sz && sz < best_sz) begin
          best_sz = sz;
          best_u = u;
          have_best = 1;
        end
      end
      u += (sz != 0) ? sz : 1;
    end
    if (exact) begin
      tags[u] = bfha_pkg::TAG_USED;
      r.addr = payload_of(u);
      return r;
    end
    if (!have_best) begin
      if (need > bfha_pkg::HeapUnits - endu) begin
        r.status = bfha_pkg::StNoMemory;
        return r;
      end
      nh = endu;
      last = endu + need - 1;
      tags[nh] = bfha_pkg::TAG_FREE;
      sizes[nh] = bfha_pkg::CntW'(need);
      links[last] = bfha_pkg::UnitW'(nh);
      if (endu != 0) begin
        p = links[endu - 1];
        // A free last block absorbs the appended space.
        if (tags[p] == bfha_pkg::TAG_FREE) begin
          sizes[p] += bfha_pkg::CntW'(need);
          links[last] = bfha_pkg::UnitW'(p);
          tags[nh] = bfha_pkg::TAG_NONE;
          sizes[nh] = '0;
          nh = p;
        end
      end
      end_unit = bfha_pkg::CntW'(endu + need);
      tags[nh] = bfha_pkg::TAG_USED;
      r.addr = payload_of(nh);
      return r;
    end
    // Split only when more than one unit would be left over.
    if (best_sz - need > 1) begin
      tail = best_u + need;
      tags[best_u] = bfha_pkg::TAG_USED;
      sizes[best_u] = bfha_pkg::CntW'(need);
      links[tail - 1] = bfha_pkg::UnitW'(best_u);
      if (tail < bfha_pkg::HeapUnits) begin
        tags[tail] = bfha_pkg::TAG_FREE;
        sizes[tail] = bfha_pkg::CntW'(best_sz - need);
      end
      links[best_u + best_sz - 1] = bfha_pkg::UnitW'(tail);
    end else begin
      tags[best_u] = bfha_pkg::TAG_USED;
    end
    r.addr = payload_of(best_u);
    return r;
  endfunction

  // Free with coalescing on the right, then on the left.
  function automatic reply_t predict_free(logic [31:0] addr);
    logic [31:0] off;
    int unsigned h, nx, p;
    reply_t r;
    r.addr = '0;
    r.status = bfha_pkg::StIgnored;
    if (addr == '0) return r;
    off = addr - base - bfha_pkg::HeadBytes;
    if (off[4:0] != '0) return r;
    if (off[31:5] >= end_unit || off[31:5] >= bfha_pkg::HeapUnits) return r;
    h = off[31:5];
    if (tags[h] != bfha_pkg::TAG_USED) return r;
    tags[h] = bfha_pkg::TAG_FREE;
    nx = h + sizes[h];
    if (nx < end_unit && nx < bfha_pkg::HeapUnits && tags[nx] == bfha_pkg::TAG_FREE) begin
      links[nx + sizes[nx] - 1] = bfha_pkg::UnitW'(h);
      sizes[h] += sizes[nx];
      tags[nx] = bfha_pkg::TAG_NONE;
      sizes[nx] = '0;
    end
    if (h > 0) begin
      p = links[h - 1];
      if (tags[p] == bfha_pkg::TAG_FREE) begin
        links[h + sizes[h] - 1] = bfha_pkg::UnitW'(p);
        sizes[p] += sizes[h];
        tags[h] = bfha_pkg::TAG_NONE;
        sizes[h] = '0;
      end
    end
    r.status = bfha_pkg::StFreed;
    return r;
  endfunction

  // Predict on each accepted request, compare each accepted reply.
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      clear_heap();
      awaited_replies.delete();
    end else begin
      if (cfg_we) base = cfg_wdata;
      if (in_valid && !in_stall) begin
        if (in_operation == bfha_pkg::OpAlloc) begin
          awaited_replies.push_back(predict_alloc(in_request_bytes));
        end else begin
          awaited_replies.push_back(predict_free(in_address));
        end
      end
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          report($sformatf("unexpected reply addr=%h status=%0d",
                           out_address_out, out_status));
        end else begin
          want = awaited_replies.pop_front();
          if (out_status !== want.status)
            report($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_address_out !== want.addr)
            report($sformatf("address got %h want %h", out_address_out, want.addr));
        end
      end
    end
    pending <= awaited_replies.size();
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = bfha_pkg::OpAlloc;
  logic [15:0] in_request_bytes = '0;
  logic [31:0] in_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_address_out;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;

  logic [31:0] heap_base_now = bfha_pkg::HeapBaseReset;
  int unsigned live_units[$];
  int unsigned freed_units[$];
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_pct = 0;

  always #10 clk = ~clk;

  best_fit_heap_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_request_bytes(in_request_bytes), .in_address(in_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_address_out(out_address_out), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  heap_result_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_request_bytes(in_request_bytes), .in_address(in_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_address_out(out_address_out), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver stalls in stretches, each with its own stall rate.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(20, 300);
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 30;
        2: stall_pct <= 60;
        default: stall_pct <= 90;
      endcase
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // Remember the units handed out, so frees can name live blocks.
  always @(posedge clk) begin
    logic [31:0] off;
    if (out_valid && !out_stall && out_status == bfha_pkg::StAllocated) begin
      off = out_address_out - heap_base_now - bfha_pkg::HeadBytes;
      live_units.push_back(off[31:5]);
    end
  end

  function automatic logic [31:0] payload_of(int unsigned unit);
    return heap_base_now + 32'(unit) * 32'd32 + bfha_pkg::HeadBytes;
  endfunction

  // Present one request and hold it until accepted.
  task automatic send(input logic op, input logic [15:0] bytes, input logic [31:0] addr);
    logic stalled;
    in_valid <= 1'b1;
    in_operation <= op;
    in_request_bytes <= bytes;
    in_address <= addr;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // Let every reply drain, then write the heap base.
  task automatic set_heap_base(input logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    heap_base_now = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random request: mostly well-formed allocates and frees, some noise.
  task automatic random_request();
    int unsigned pick, idx, unit;
    logic [15:0] bytes;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      case ($urandom_range(0, 9))
        0: bytes = 16'($urandom);
        1: bytes = 16'($urandom_range(500, 4000));
        default: bytes = 16'($urandom_range(0, 300));
      endcase
      send(bfha_pkg::OpAlloc, bytes, 32'($urandom));
    end else if (pick < 85 && live_units.size() != 0) begin
      idx = $urandom_range(0, live_units.size() - 1);
      unit = live_units[idx];
      live_units.delete(idx);
      freed_units.push_back(unit);
      if (freed_units.size() > 16) void'(freed_units.pop_front());
      send(bfha_pkg::OpFree, 16'($urandom), payload_of(unit));
    end else begin
      case ($urandom_range(0, 3))
        0: send(bfha_pkg::OpFree, 16'($urandom), '0);
        1: send(bfha_pkg::OpFree, 16'($urandom),
                payload_of($urandom_range(0, 2047)) + 32'($urandom_range(1, 31)));
        2: send(bfha_pkg::OpFree, 16'($urandom),
                (freed_units.size() != 0) ? payload_of(freed_units[0]) : 32'($urandom));
        default: send(bfha_pkg::OpFree, 16'($urandom), 32'($urandom));
      endcase
    end
  endtask

  task automatic random_phase(input int count);
    int gap;
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      random_request();
    end
  endtask

  // Stimulus: directed corner cases, then random phases across base settings.
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send(bfha_pkg::OpAlloc, 16'd16, '0);
    send(bfha_pkg::OpAlloc, 16'd0, '0);
    send(bfha_pkg::OpAlloc, 16'hFFFF, '0);
    send(bfha_pkg::OpAlloc, 16'd4000, '0);
    send(bfha_pkg::OpAlloc, 16'd17, '0);
    send(bfha_pkg::OpFree, 16'd0, '0);
    send(bfha_pkg::OpFree, 16'd0, payload_of(1) + 32'd4);
    send(bfha_pkg::OpFree, 16'd0, payload_of(1000));
    send(bfha_pkg::OpFree, 16'd0, payload_of(1));
    send(bfha_pkg::OpFree, 16'd0, payload_of(1));
    send(bfha_pkg::OpFree, 16'd0, payload_of(2));
    send(bfha_pkg::OpFree, 16'd0, payload_of(0));
    send(bfha_pkg::OpFree, 16'd0, payload_of(128));
    send(bfha_pkg::OpAlloc, 16'd4176, '0);
    send(bfha_pkg::OpFree, 16'd0, payload_of(0));
    send(bfha_pkg::OpAlloc, 16'd48, '0);
    send(bfha_pkg::OpAlloc, 16'd8240, '0);
    send(bfha_pkg::OpFree, 16'd0, payload_of(4));
    send(bfha_pkg::OpFree, 16'd0, payload_of(2));
    send(bfha_pkg::OpFree, 16'd0, payload_of(0));
    send(bfha_pkg::OpFree, 16'hFFFF, 32'hFFFF_FFFF);
    send(bfha_pkg::OpAlloc, 16'd100, 32'hFFFF_FFFF);
    live_units.delete();

    set_heap_base(32'h0000_0000);
    random_phase(70);
    set_heap_base(32'hFFFF_FFFF);
    random_phase(70);
    set_heap_base(32'($urandom));
    random_phase(70);
    set_heap_base(bfha_pkg::HeapBaseReset);
    random_phase(70);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #150_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
sv/bfha_pkg.sv
sv/bfha_engine.sv
sv/best_fit_heap_allocator.sv
tb/sv/heap_result_checker.sv
tb/sv/tb.sv
